// File: rtl/core/swhm_pkg.sv
package swhm_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int LAT_W       = 16;
    localparam int PTR_W       = $clog2(MAX_WINDOW);
    localparam int FILL_W      = $clog2(MAX_WINDOW + 1);
    localparam int SLOT_W      = PTR_W + 1;
    localparam int SUM_W       = LAT_W + PTR_W;
    localparam int DIV_W       = SUM_W;
    localparam int CNT_W       = $clog2(DIV_W);
    localparam int RING_W      = LAT_W + 1;

    localparam int WIN_W       = 7;
    localparam int PCT_W       = 7;
    localparam int LIMIT_W     = 16;
    localparam int PROD_W      = FILL_W + PCT_W;
    localparam int CTR_W       = 32;

    localparam int OUT_MEAN_W  = 16;
    localparam int OUT_FILL_W  = 7;
    localparam int OUT_LAT_W   = 16;

    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 144;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 2'd2;

    localparam logic [WIN_W-1:0]   WINDOW_RST   = 7'd20;
    localparam logic [PCT_W-1:0]   THRESH_RST   = 7'd95;
    localparam logic [LIMIT_W-1:0] LIMIT_RST    = 16'd500;

    localparam int MIN_DEPTH    = 5;
    localparam int MIN_FILL     = 3;
    localparam int PCT_FULL     = 100;

    typedef struct packed {
        logic accept;
        logic rd;
        logic drop;
        logic append;
        logic div_start;
        logic div_step;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic over_depth;
        logic out_free;
    } t_status;

endpackage

// File: rtl/core/swhm_ram.sv
module swhm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/swhm_ctrl.sv
module swhm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  swhm_pkg::t_status i_status,
    output swhm_pkg::t_cmd    o_cmd
);
    import swhm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE_RD,
        S_PRE_AP,
        S_WRITE,
        S_TRIM_CHK,
        S_TRIM_AP,
        S_DIV,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_status.full ? S_PRE_RD : S_WRITE;
                end
            end
            S_PRE_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_PRE_AP;
            end
            S_PRE_AP: begin
                o_cmd.drop = 1'b1;
                n_state    = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.append = 1'b1;
                n_state      = S_TRIM_CHK;
            end
            S_TRIM_CHK: begin
                if (i_status.over_depth) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_TRIM_AP;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_cnt           = '0;
                    n_state         = S_DIV;
                end
            end
            S_TRIM_AP: begin
                o_cmd.drop = 1'b1;
                n_state    = S_TRIM_CHK;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// File: rtl/core/swhm_dp.sv
module swhm_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  swhm_pkg::t_cmd                   i_cmd,
    output swhm_pkg::t_status                o_status,
    input  logic                             i_cfg_we,
    input  logic [swhm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [swhm_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic [swhm_pkg::IN_TDATA_W-1:0]  i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [swhm_pkg::OUT_TDATA_W-1:0] o_out_data
);
    import swhm_pkg::*;

    logic [WIN_W-1:0]   r_window;
    logic [PCT_W-1:0]   r_thresh;
    logic [LIMIT_W-1:0] r_limit;

    logic [PTR_W-1:0]   r_head;
    logic [FILL_W-1:0]  r_fill;
    logic [FILL_W-1:0]  r_okcnt;
    logic [SUM_W-1:0]   r_sum;
    logic [CTR_W-1:0]   r_req, r_succ, r_err;
    logic               r_ok;
    logic [LAT_W-1:0]   r_lat;

    logic [DIV_W-1:0]   r_mq, r_pq;
    logic [FILL_W-1:0]  r_mr, r_pr;

    logic                  r_out_valid;
    logic                  r_o_bad;
    logic [OUT_MEAN_W-1:0] r_o_mean;
    logic [PCT_W-1:0]      r_o_pct;
    logic [OUT_FILL_W-1:0] r_o_fill;
    logic [CTR_W-1:0]      r_o_req, r_o_succ, r_o_err;
    logic [OUT_LAT_W-1:0]  r_o_lat;

    logic               w_in_ok;
    logic [LAT_W-1:0]   w_in_lat;
    logic [PTR_W-1:0]   w_head_inc;
    logic [SLOT_W-1:0]  w_slot_sum;
    logic [PTR_W-1:0]   w_slot;
    logic [RING_W-1:0]  w_rdata;
    logic               w_rd_ok;
    logic [LAT_W-1:0]   w_rd_lat;
    logic [FILL_W-1:0]  w_depth;
    logic [WIN_W-1:0]   w_quarter;
    logic [FILL_W-1:0]  w_min_fill;
    logic [FILL_W:0]    w_mtrial, w_ptrial;
    logic               w_mge, w_pge;
    logic [LAT_W-1:0]   w_mean;
    logic [PCT_W-1:0]   w_pct;
    logic [PROD_W-1:0]  w_ok100, w_thr_fill;
    logic               w_bad;
    logic               w_out_free;

    assign w_in_ok  = i_in_data[0];
    assign w_in_lat = i_in_data[LAT_W:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RST;
            r_thresh <= THRESH_RST;
            r_limit  <= LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WINDOW: r_window <= i_cfg_data[WIN_W-1:0];
                REG_THRESH: r_thresh <= i_cfg_data[PCT_W-1:0];
                REG_LIMIT:  r_limit  <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_head_inc = (r_head == PTR_W'(MAX_WINDOW - 1)) ? '0 : r_head + 1'b1;
    assign w_slot_sum = SLOT_W'(r_head) + SLOT_W'(r_fill);
    assign w_slot     = (w_slot_sum >= SLOT_W'(MAX_WINDOW))
                      ? PTR_W'(w_slot_sum - SLOT_W'(MAX_WINDOW))
                      : w_slot_sum[PTR_W-1:0];

    swhm_ram #(
        .WIDTH (RING_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.append),
        .i_waddr (w_slot),
        .i_wdata ({r_ok, r_lat}),
        .i_re    (i_cmd.rd),
        .i_raddr (r_head),
        .o_rdata (w_rdata)
    );

    assign w_rd_ok  = w_rdata[LAT_W];
    assign w_rd_lat = w_rdata[LAT_W-1:0];

    always_comb begin
        if (r_window < WIN_W'(MIN_DEPTH)) begin
            w_depth = FILL_W'(MIN_DEPTH);
        end else if (FILL_W'(r_window) > FILL_W'(MAX_WINDOW)) begin
            w_depth = FILL_W'(MAX_WINDOW);
        end else begin
            w_depth = FILL_W'(r_window);
        end
    end

    assign w_quarter  = r_window >> 2;
    assign w_min_fill = (w_quarter < WIN_W'(MIN_FILL)) ? FILL_W'(MIN_FILL)
                                                       : FILL_W'(w_quarter);

    // one restoring step for each of the two quotients
    assign w_mtrial = {r_mr, r_mq[DIV_W-1]};
    assign w_ptrial = {r_pr, r_pq[DIV_W-1]};
    assign w_mge    = w_mtrial >= {1'b0, r_okcnt};
    assign w_pge    = w_ptrial >= {1'b0, r_fill};

    assign w_mean     = (r_okcnt == '0) ? '0 : r_mq[LAT_W-1:0];
    assign w_pct      = (r_fill == '0) ? PCT_W'(PCT_FULL) : r_pq[PCT_W-1:0];
    assign w_ok100    = PROD_W'(r_okcnt) * PROD_W'(PCT_FULL);
    assign w_thr_fill = PROD_W'(r_thresh) * PROD_W'(r_fill);
    assign w_bad      = (r_fill >= w_min_fill) &&
                        ((w_ok100 < w_thr_fill) || (LIMIT_W'(w_mean) > r_limit));

    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_status.full       = (r_fill >= FILL_W'(MAX_WINDOW));
    assign o_status.over_depth = (r_fill > w_depth);
    assign o_status.out_free   = w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_fill      <= '0;
            r_okcnt     <= '0;
            r_sum       <= '0;
            r_req       <= '0;
            r_succ      <= '0;
            r_err       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                if (r_req != '1) begin
                    r_req <= r_req + 1'b1;
                end
                if (w_in_ok) begin
                    if (r_succ != '1) begin
                        r_succ <= r_succ + 1'b1;
                    end
                end else if (r_err != '1) begin
                    r_err <= r_err + 1'b1;
                end
            end
            if (i_cmd.drop) begin
                r_head <= w_head_inc;
                r_fill <= r_fill - 1'b1;
                if (w_rd_ok) begin
                    r_okcnt <= r_okcnt - 1'b1;
                    r_sum   <= r_sum - SUM_W'(w_rd_lat);
                end
            end
            if (i_cmd.append) begin
                r_fill <= r_fill + 1'b1;
                if (r_ok) begin
                    r_okcnt <= r_okcnt + 1'b1;
                    r_sum   <= r_sum + SUM_W'(r_lat);
                end
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ok  <= w_in_ok;
            r_lat <= w_in_lat;
        end
        if (i_cmd.div_start) begin
            r_mq <= DIV_W'(r_sum);
            r_mr <= '0;
            r_pq <= DIV_W'(w_ok100);
            r_pr <= '0;
        end else if (i_cmd.div_step) begin
            r_mq <= {r_mq[DIV_W-2:0], w_mge};
            r_mr <= w_mge ? FILL_W'(w_mtrial - {1'b0, r_okcnt}) : w_mtrial[FILL_W-1:0];
            r_pq <= {r_pq[DIV_W-2:0], w_pge};
            r_pr <= w_pge ? FILL_W'(w_ptrial - {1'b0, r_fill}) : w_ptrial[FILL_W-1:0];
        end
        if (i_cmd.load) begin
            r_o_bad  <= w_bad;
            r_o_mean <= OUT_MEAN_W'(w_mean);
            r_o_pct  <= w_pct;
            r_o_fill <= OUT_FILL_W'(r_fill);
            r_o_req  <= r_req;
            r_o_succ <= r_succ;
            r_o_err  <= r_err;
            r_o_lat  <= OUT_LAT_W'(r_lat);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {1'b0, r_o_lat, r_o_err, r_o_succ, r_o_req,
                          r_o_fill, r_o_pct, r_o_mean, r_o_bad};

endmodule

// File: rtl/core/sliding_window_health_monitor_top.sv
// Sliding-window health monitor.
// Input stream (s_axis_*): one attempt per transfer, tdata = {latency_ms, attempt_ok}.
// Output stream (m_axis_*): one result per input transfer, holding the window
// statistics and saturating counters after that attempt is recorded.
// Config: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 window_size, 1 success_threshold_pct, 2 latency_limit_ms); write only while idle.
// Processing: the input transfer is accepted, the oldest sample drops first if the
// ring is full, the attempt is appended, each sample beyond the window depth then
// drops (one ring read, one update), and the 22-step serial divider (mean latency
// and success percentage in parallel) runs before m_axis_tvalid rises. Once at depth
// one sample drops per item; shrinking window_size drops up to 60 samples in one item.
// One item is processed at a time; s_axis_tready is high only between items and
// returns the cycle after the result loads.
// The result sits in an output register: when m_axis_tready is low the next
// item is still accepted and processed, and it waits only to load its result.
// Reset (synchronous, active low) empties the window, clears the counters and
// restores the registers to 20, 95 and 500. Ring contents need no clearing.
module sliding_window_health_monitor_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [0] attempt_ok, [16:1] latency_ms, [23:17] zero
    input  logic [swhm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] unhealthy, [16:1] mean_latency_ms, [23:17] success_pct,
    // [30:24] window_fill, [62:31] total_requests, [94:63] total_successes,
    // [126:95] total_errors, [142:127] latest_latency_ms, [143] zero
    output logic [swhm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [swhm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [swhm_pkg::CFG_W-1:0]       i_cfg_data
);
    import swhm_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    swhm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    swhm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// File: rtl/core/swhm_chk.sv
module swhm_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [swhm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [swhm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             i_cfg_we,
    input logic [swhm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input logic [swhm_pkg::CFG_W-1:0]       i_cfg_data
);

    // one item in flight: no transfer on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted on consecutive cycles");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[30:24] != 7'd0) && (m_axis_tdata[30:24] <= 7'd64))
        else $error("window fill out of range");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[23:17] <= 7'd100))
        else $error("success percentage above 100");

    // a result loads only while an item is being processed
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result shown while idle for input");

endmodule

bind sliding_window_health_monitor_top swhm_chk u_swhm_chk (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import swhm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic                  pad;
        logic [OUT_LAT_W-1:0]  latest_lat;
        logic [CTR_W-1:0]      errors;
        logic [CTR_W-1:0]      successes;
        logic [CTR_W-1:0]      requests;
        logic [OUT_FILL_W-1:0] fill;
        logic [PCT_W-1:0]      pct;
        logic [OUT_MEAN_W-1:0] mean;
        logic                  unhealthy;
    } t_health_rec;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [0] attempt_ok, [16:1] latency_ms, [23:17] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [0] unhealthy, [16:1] mean_latency_ms, [23:17] success_pct, [30:24] window_fill,
    // [62:31] total_requests, [94:63] total_successes, [126:95] total_errors,
    // [142:127] latest_latency_ms, [143] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;

    sliding_window_health_monitor_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // window model
    logic             win_ok [MAX_WINDOW];
    logic [LAT_W-1:0] win_lat [MAX_WINDOW];
    int unsigned      win_head;
    int unsigned      win_fill;
    int unsigned      win_ok_cnt;
    longint unsigned  win_lat_sum;
    logic [CTR_W-1:0] n_requests;
    logic [CTR_W-1:0] n_successes;
    logic [CTR_W-1:0] n_errors;
    logic [WIN_W-1:0]   cfg_window;
    logic [PCT_W-1:0]   cfg_thresh;
    logic [LIMIT_W-1:0] cfg_limit;

    t_health_rec health_expected[$];
    t_health_rec got_rec;
    t_health_rec want_rec;
    int          fail_count = 0;
    int          result_count = 0;
    int          cycle_count = 0;
    bit          no_idle = 1'b0;

    function automatic void reset_window_model();
        win_head    = 0;
        win_fill    = 0;
        win_ok_cnt  = 0;
        win_lat_sum = 0;
        n_requests  = '0;
        n_successes = '0;
        n_errors    = '0;
        cfg_window  = WINDOW_RST;
        cfg_thresh  = THRESH_RST;
        cfg_limit   = LIMIT_RST;
    endfunction

    function automatic void retire_oldest();
        if (win_fill == 0) return;
        if (win_ok[win_head]) begin
            win_ok_cnt--;
            win_lat_sum -= win_lat[win_head];
        end
        win_head = (win_head + 1) % MAX_WINDOW;
        win_fill--;
    endfunction

    function automatic t_health_rec record_attempt(input logic ok, input logic [LAT_W-1:0] lat);
        t_health_rec r;
        int unsigned depth;
        int unsigned min_fill;
        int unsigned slot;
        int unsigned mean;
        int unsigned pct;
        r = '0;
        if (n_requests != '1) n_requests++;
        depth = (cfg_window < MIN_DEPTH) ? MIN_DEPTH : cfg_window;
        if (depth > MAX_WINDOW) depth = MAX_WINDOW;
        if (win_fill >= MAX_WINDOW) retire_oldest();
        slot = (win_head + win_fill) % MAX_WINDOW;
        win_ok[slot]  = ok;
        win_lat[slot] = lat;
        win_fill++;
        if (ok) begin
            win_ok_cnt++;
            win_lat_sum += lat;
        end
        while (win_fill > depth) retire_oldest();
        if (ok) begin
            if (n_successes != '1) n_successes++;
        end else if (n_errors != '1) begin
            n_errors++;
        end
        mean = (win_ok_cnt != 0) ? 32'(win_lat_sum / win_ok_cnt) : 0;
        pct  = (win_fill != 0) ? (win_ok_cnt * 100) / win_fill : PCT_FULL;
        min_fill = cfg_window / 4;
        if (min_fill < MIN_FILL) min_fill = MIN_FILL;
        if (win_fill >= min_fill) begin
            if (longint'(win_ok_cnt) * 100 < longint'(cfg_thresh) * win_fill)
                r.unhealthy = 1'b1;
            else if (mean > cfg_limit)
                r.unhealthy = 1'b1;
        end
        r.mean       = OUT_MEAN_W'(mean);
        r.pct        = PCT_W'(pct);
        r.fill       = OUT_FILL_W'(win_fill);
        r.requests   = n_requests;
        r.successes  = n_successes;
        r.errors     = n_errors;
        r.latest_lat = OUT_LAT_W'(lat);
        return r;
    endfunction

    function automatic int pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(13, 30);
    endfunction

    function automatic logic [LAT_W-1:0] pick_latency(input int mode);
        int v;
        case (mode)
            0: v = $urandom_range(0, 65535);
            1: v = int'(cfg_limit) + int'($urandom_range(0, 600)) - 300;
            default: begin
                case ($urandom_range(0, 3))
                    0: v = 0;
                    1: v = 65535;
                    default: v = $urandom_range(0, 1000);
                endcase
            end
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[LAT_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (fail_count < 100)
            $display("[%0t] result %0d: %s got %0d expected %0d",
                     $time, result_count, what, got, want);
        fail_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_rec = m_axis_tdata;
            if (health_expected.size() == 0) begin
                report_mismatch("result with nothing pending, requests", got_rec.requests, 0);
            end else begin
                want_rec = health_expected[0];
                health_expected.delete(0);
                if (got_rec.unhealthy !== want_rec.unhealthy)
                    report_mismatch("unhealthy", got_rec.unhealthy, want_rec.unhealthy);
                if (got_rec.mean !== want_rec.mean)
                    report_mismatch("mean_latency_ms", got_rec.mean, want_rec.mean);
                if (got_rec.pct !== want_rec.pct)
                    report_mismatch("success_pct", got_rec.pct, want_rec.pct);
                if (got_rec.fill !== want_rec.fill)
                    report_mismatch("window_fill", got_rec.fill, want_rec.fill);
                if (got_rec.requests !== want_rec.requests)
                    report_mismatch("total_requests", got_rec.requests, want_rec.requests);
                if (got_rec.successes !== want_rec.successes)
                    report_mismatch("total_successes", got_rec.successes, want_rec.successes);
                if (got_rec.errors !== want_rec.errors)
                    report_mismatch("total_errors", got_rec.errors, want_rec.errors);
                if (got_rec.latest_lat !== want_rec.latest_lat)
                    report_mismatch("latest_latency_ms", got_rec.latest_lat, want_rec.latest_lat);
            end
            result_count++;
        end
    end

    // downstream backpressure
    initial begin
        int run_left;
        int stall_left;
        run_left = 0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                m_axis_tready <= 1'b1;
            end else begin
                run_left   = no_idle ? 200 : $urandom_range(0, 24);
                stall_left = no_idle ? 0 : pick_delay();
                m_axis_tready <= (stall_left == 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // tvalid stays high after a transfer until the next call or a drain decides
    task automatic send_attempt(input logic ok, input logic [LAT_W-1:0] lat);
        int gap;
        gap = no_idle ? 0 : pick_delay();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_TDATA_W'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - LAT_W - 1){1'b0}}, lat, ok};
        do @(posedge i_clk); while (!s_axis_tready);
        health_expected = {health_expected, record_attempt(ok, lat)};
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (health_expected.size() != 0);
    endtask

    task automatic quiesce();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_WINDOW: cfg_window = value[WIN_W-1:0];
            REG_THRESH: cfg_thresh = value[PCT_W-1:0];
            REG_LIMIT:  cfg_limit  = value[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic test_reset_defaults();
        send_attempt(1'b1, 16'd0);
        send_attempt(1'b1, 16'hFFFF);
        send_attempt(1'b0, 16'hFFFF);
        send_attempt(1'b0, 16'd0);
        send_attempt(1'b1, 16'd500);
        send_attempt(1'b1, 16'd501);
    endtask

    // depth floor of five, minimum fill of three, zero latency limit
    task automatic test_small_window();
        quiesce();
        write_reg(REG_WINDOW, 16'd0);
        write_reg(REG_THRESH, 16'd100);
        write_reg(REG_LIMIT, 16'd0);
        send_attempt(1'b1, 16'd0);
        send_attempt(1'b1, 16'd0);
        send_attempt(1'b1, 16'd0);
        send_attempt(1'b1, 16'd1);
        send_attempt(1'b1, 16'd7);
        send_attempt(1'b0, 16'hFFFF);
    endtask

    // high bits beyond register width, threshold over 100, unused index
    task automatic test_register_masking();
        quiesce();
        write_reg(REG_WINDOW, 16'hFF84);
        write_reg(REG_THRESH, 16'hFF7F);
        write_reg(REG_LIMIT, 16'hFFFF);
        write_reg(REG_UNUSED, 16'h0001);
        send_attempt(1'b1, 16'hFFFF);
        send_attempt(1'b0, 16'd0);
        send_attempt(1'b1, 16'd12345);
        send_attempt(1'b1, 16'hFFFF);
    endtask

    // oversized window saturates at the ring depth, then a shrink to the floor
    task automatic test_window_shrink();
        quiesce();
        write_reg(REG_WINDOW, 16'd127);
        write_reg(REG_THRESH, 16'd90);
        write_reg(REG_LIMIT, 16'd40000);
        for (int i = 0; i < 70; i++)
            send_attempt($urandom_range(0, 9) != 0, LAT_W'($urandom_range(0, 65535)));
        quiesce();
        write_reg(REG_WINDOW, 16'd1);
        for (int i = 0; i < 4; i++)
            send_attempt(i != 2, pick_latency(2));
    endtask

    task automatic test_random_phases(input int n_phases, input int per_phase);
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] th;
        logic [CFG_W-1:0] lim;
        int ok_pct;
        int lat_mode;
        for (int p = 0; p < n_phases; p++) begin
            quiesce();
            case ($urandom_range(0, 5))
                0: w = '0;
                1: w = CFG_W'($urandom_range(1, 4));
                2: w = 16'd5;
                3: w = CFG_W'($urandom_range(6, 63));
                4: w = 16'd64;
                default: w = CFG_W'($urandom_range(65, 127));
            endcase
            case ($urandom_range(0, 4))
                0: th = '0;
                1: th = 16'd100;
                2: th = CFG_W'($urandom_range(101, 127));
                3: th = CFG_W'($urandom_range(50, 99));
                default: th = CFG_W'($urandom_range(0, 100));
            endcase
            case ($urandom_range(0, 3))
                0: lim = '0;
                1: lim = 16'hFFFF;
                2: lim = CFG_W'($urandom_range(0, 65535));
                default: lim = CFG_W'($urandom_range(50, 3000));
            endcase
            if ($urandom_range(0, 3) == 0) w[CFG_W-1:WIN_W] = (CFG_W - WIN_W)'($urandom);
            if ($urandom_range(0, 3) == 0) th[CFG_W-1:PCT_W] = (CFG_W - PCT_W)'($urandom);
            write_reg(REG_WINDOW, w);
            write_reg(REG_THRESH, th);
            write_reg(REG_LIMIT, lim);
            ok_pct   = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(30, 99);
            lat_mode = $urandom_range(0, 2);
            no_idle  = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < per_phase; i++) begin
                send_attempt($urandom_range(1, 100) <= ok_pct, pick_latency(lat_mode));
                if ((p == 0 && i == per_phase / 2) || $urandom_range(0, 149) == 0)
                    drain_results();
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        reset_window_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_small_window();
        test_register_masking();
        test_window_shrink();
        test_random_phases(20, 78);
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && health_expected.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
